@@ hw/rtl/sppi_pkg.sv @@
// Shared types, constants and tables for the segment path pose integrator.
// Used by the controller, datapath, register block and top level.
`timescale 1ns / 1ps

package sppi_pkg;

  localparam int unsigned CORDIC_ITERATIONS = 16;
  localparam int unsigned ITER_W = $clog2(CORDIC_ITERATIONS);
  localparam int unsigned ATAN_COUNT = 24;
  localparam int unsigned ATAN_IDX_W = 5;
  localparam int unsigned ATAN_W = 22;

  localparam int unsigned MS_W = 16;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned TURN_W = 17;
  localparam int unsigned PROD_W = 32;
  localparam int unsigned LEN_W = 24;
  localparam int unsigned POS_W = 32;
  localparam int unsigned HEAD_W = 19;
  localparam int unsigned VEC_W = 34;
  localparam int unsigned ANG_W = 25;
  localparam int unsigned LENK_W = 24;
  localparam int unsigned GAIN_W = 30;

  localparam logic [LENK_W-1:0] LEN_K = 24'd9624813;
  localparam logic [GAIN_W-1:0] CORDIC_GAIN = 30'd652032874;
  localparam logic signed [HEAD_W-1:0] HEAD_START = 19'sd16384;
  localparam logic signed [HEAD_W-1:0] FULL_TURN = 19'sd65536;
  localparam logic signed [TURN_W-1:0] TURN_RESET = -17'sd26214;

  localparam int unsigned OUT_TDATA_W = 88;
  localparam int unsigned PADDR_W = 3;

  typedef enum logic [0:0] {
    REG_SPEED = 1'b0,
    REG_TURN  = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_GAIN,
    ST_ROT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic len;
    logic gain;
    logic rot;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic last_iter;
    logic out_busy;
  } status_t;

  function automatic logic [ATAN_W-1:0] atan_lookup(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] val;
    case (idx)
      5'd0:    val = 22'd2097152;
      5'd1:    val = 22'd1238021;
      5'd2:    val = 22'd654136;
      5'd3:    val = 22'd332050;
      5'd4:    val = 22'd166669;
      5'd5:    val = 22'd83416;
      5'd6:    val = 22'd41718;
      5'd7:    val = 22'd20860;
      5'd8:    val = 22'd10430;
      5'd9:    val = 22'd5215;
      5'd10:   val = 22'd2608;
      5'd11:   val = 22'd1304;
      5'd12:   val = 22'd652;
      5'd13:   val = 22'd326;
      5'd14:   val = 22'd163;
      5'd15:   val = 22'd81;
      5'd16:   val = 22'd41;
      5'd17:   val = 22'd20;
      5'd18:   val = 22'd10;
      5'd19:   val = 22'd5;
      5'd20:   val = 22'd3;
      5'd21:   val = 22'd1;
      5'd22:   val = 22'd1;
      default: val = 22'd0;
    endcase
    return val;
  endfunction

endpackage

@@ hw/rtl/segment_path_pose_integrator.sv @@
// Top level of the segment path pose integrator: register block, sequencer
// and datapath. Depends on sppi_pkg, sppi_cfg, sppi_ctrl, sppi_datapath.
`timescale 1ns / 1ps

// Each accepted segment steps through length, gain, CORDIC_ITERATIONS
// micro-rotations of the shared iterative CORDIC rotator and the pose update,
// one step a cycle while the pose update does not wait. Its result is then
// held in the output register. A new segment is taken in the cycle after the
// pose update, while the previous result may still wait in the output
// register; the pose update waits only while that register is full and not
// taken. Configure speed and turn angle only while no segment is in work.

module segment_path_pose_integrator
  import sppi_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [MS_W-1:0]        s_axis_tdata,  // [15:0] duration_ms
  input  logic                   s_axis_tuser,  // [0] start_path
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [31:0] x_pos, [63:32] y_pos, [82:64] heading, [87:83] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tuser   // [0] saturated
);

  logic [SPEED_W-1:0]       speed;
  logic signed [TURN_W-1:0] turn;
  cmd_t                     cmd;
  status_t                  status;
  logic signed [POS_W-1:0]  x_pos, y_pos;
  logic signed [HEAD_W-1:0] heading;

  sppi_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .speed_o (speed),
    .turn_o  (turn)
  );

  sppi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sppi_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .speed_i     (speed),
    .turn_i      (turn),
    .ms_i        (s_axis_tdata),
    .start_i     (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .x_o         (x_pos),
    .y_o         (y_pos),
    .head_o      (heading),
    .sat_o       (m_axis_tuser)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-2*POS_W-HEAD_W){1'b0}}, heading, y_pos, x_pos};

endmodule

@@ hw/rtl/sppi_cfg.sv @@
// APB register block: motor speed and turn angle.
// Depends on sppi_pkg.
`timescale 1ns / 1ps

module sppi_cfg
  import sppi_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output logic [SPEED_W-1:0]       speed_o,
  output logic signed [TURN_W-1:0] turn_o
);

  logic [SPEED_W-1:0]       speed_q;
  logic signed [TURN_W-1:0] turn_q;
  reg_idx_e                 idx;
  logic                     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= '0;
      turn_q  <= TURN_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_SPEED: speed_q <= pwdata[SPEED_W-1:0];
        REG_TURN:  turn_q  <= pwdata[TURN_W-1:0];
        default:   speed_q <= speed_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SPEED: prdata = {{(32-SPEED_W){1'b0}}, speed_q};
      REG_TURN:  prdata = {{(32-TURN_W){turn_q[TURN_W-1]}}, turn_q};
      default:   prdata = '0;
    endcase
  end

  assign speed_o = speed_q;
  assign turn_o  = turn_q;

endmodule

@@ hw/rtl/sppi_ctrl.sv @@
// Sequencer: steps one segment through length, gain, CORDIC and pose update.
// Depends on sppi_pkg.
`timescale 1ns / 1ps

module sppi_ctrl
  import sppi_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_LEN;
      ST_LEN:  state_d = ST_GAIN;
      ST_GAIN: state_d = ST_ROT;
      ST_ROT:  if (status_i.last_iter) state_d = ST_DONE;
      ST_DONE: if (!status_i.out_busy) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_LEN:  cmd_o.len  = 1'b1;
      ST_GAIN: cmd_o.gain = 1'b1;
      ST_ROT:  cmd_o.rot  = 1'b1;
      ST_DONE: cmd_o.done = !status_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ hw/rtl/sppi_datapath.sv @@
// Datapath: heading update, segment length, gain, iterative CORDIC, pose
// accumulate with saturation, and the result register. Depends on sppi_pkg.
`timescale 1ns / 1ps

module sppi_datapath
  import sppi_pkg::*;
(
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cmd_t                            cmd_i,
  output status_t                         status_o,
  input  logic [SPEED_W-1:0]              speed_i,
  input  logic signed [TURN_W-1:0]        turn_i,
  input  logic [MS_W-1:0]                 ms_i,
  input  logic                            start_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [POS_W-1:0]         x_o,
  output logic signed [POS_W-1:0]         y_o,
  output logic signed [HEAD_W-1:0]        head_o,
  output logic                            sat_o
);

  logic signed [POS_W-1:0]  pose_x_q, pose_y_q;
  logic signed [HEAD_W-1:0] head_q;
  logic [PROD_W-1:0]        prod_q;
  logic [LEN_W-1:0]         len_q;
  logic signed [VEC_W-1:0]  x_q, y_q;
  logic signed [ANG_W-1:0]  z_q;
  logic [ITER_W-1:0]        iter_q;

  logic                     out_valid_q;
  logic signed [POS_W-1:0]  out_x_q, out_y_q;
  logic signed [HEAD_W-1:0] out_head_q;
  logic                     out_sat_q;

  logic signed [HEAD_W-1:0] head_sum, head_wrap;
  logic [PROD_W+LENK_W:0]   len_full;
  logic [LEN_W+GAIN_W:0]    gain_full;
  logic signed [VEC_W-1:0]  xs, ys;
  logic signed [ANG_W-1:0]  atan_v;
  logic signed [VEC_W-1:0]  c_v, s_v, dx, dy;
  logic signed [VEC_W-1:0]  sum_x, sum_y;
  logic                     clip_x, clip_y;
  logic signed [POS_W-1:0]  new_x, new_y;

  localparam logic signed [VEC_W-1:0] POS_MAX = VEC_W'(2147483647);
  localparam logic signed [VEC_W-1:0] POS_MIN =
    {{(VEC_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};

  assign head_sum = head_q + {{(HEAD_W-TURN_W){turn_i[TURN_W-1]}}, turn_i};

  always_comb begin
    head_wrap = head_sum;
    if (head_sum > FULL_TURN) begin
      head_wrap = head_sum - FULL_TURN;
    end else if (head_sum < -FULL_TURN) begin
      head_wrap = head_sum + FULL_TURN;
    end
  end

  assign len_full  = prod_q * LEN_K + (PROD_W+LENK_W+1)'(64'h8000_0000);
  assign gain_full = len_q * CORDIC_GAIN + (LEN_W+GAIN_W+1)'(64'h2000_0000);

  assign xs     = x_q >>> iter_q;
  assign ys     = y_q >>> iter_q;
  assign atan_v = ANG_W'(atan_lookup(ATAN_IDX_W'(iter_q)));

  always_comb begin
    case (head_q[15:14])
      2'd0:    begin c_v = x_q;  s_v = y_q;  end
      2'd1:    begin c_v = -y_q; s_v = x_q;  end
      2'd2:    begin c_v = -x_q; s_v = -y_q; end
      default: begin c_v = y_q;  s_v = -x_q; end
    endcase
  end

  assign dx    = (c_v + VEC_W'(128)) >>> 8;
  assign dy    = (s_v + VEC_W'(128)) >>> 8;
  assign sum_x = {{(VEC_W-POS_W){pose_x_q[POS_W-1]}}, pose_x_q} + dx;
  assign sum_y = {{(VEC_W-POS_W){pose_y_q[POS_W-1]}}, pose_y_q} + dy;

  always_comb begin
    clip_x = 1'b1;
    clip_y = 1'b1;
    if (sum_x > POS_MAX) begin
      new_x = POS_MAX[POS_W-1:0];
    end else if (sum_x < POS_MIN) begin
      new_x = POS_MIN[POS_W-1:0];
    end else begin
      new_x  = sum_x[POS_W-1:0];
      clip_x = 1'b0;
    end
    if (sum_y > POS_MAX) begin
      new_y = POS_MAX[POS_W-1:0];
    end else if (sum_y < POS_MIN) begin
      new_y = POS_MIN[POS_W-1:0];
    end else begin
      new_y  = sum_y[POS_W-1:0];
      clip_y = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_x_q    <= '0;
      pose_y_q    <= '0;
      head_q      <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (start_i) begin
          pose_x_q <= '0;
          pose_y_q <= '0;
          head_q   <= HEAD_START;
        end else begin
          head_q <= head_wrap;
        end
      end
      if (cmd_i.gain) begin
        iter_q <= '0;
      end else if (cmd_i.rot) begin
        iter_q <= iter_q + ITER_W'(1);
      end
      if (cmd_i.done) begin
        pose_x_q    <= new_x;
        pose_y_q    <= new_y;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      prod_q <= speed_i * ms_i;
    end
    if (cmd_i.len) begin
      len_q <= len_full[PROD_W+LENK_W-1:32];
    end
    if (cmd_i.gain) begin
      x_q <= {{(VEC_W-LEN_W-8){1'b0}}, gain_full[LEN_W+GAIN_W-1:GAIN_W], 8'd0};
      y_q <= '0;
      z_q <= {{(ANG_W-22){1'b0}}, head_q[13:0], 8'd0};
    end
    if (cmd_i.rot) begin
      if (!z_q[ANG_W-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_v;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_v;
      end
    end
    if (cmd_i.done) begin
      out_x_q    <= new_x;
      out_y_q    <= new_y;
      out_head_q <= head_q;
      out_sat_q  <= clip_x | clip_y;
    end
  end

  assign status_o.last_iter = (iter_q == ITER_W'(CORDIC_ITERATIONS - 1));
  assign status_o.out_busy  = out_valid_q & ~out_ready_i;

  assign out_valid_o = out_valid_q;
  assign x_o         = out_x_q;
  assign y_o         = out_y_q;
  assign head_o      = out_head_q;
  assign sat_o       = out_sat_q;

endmodule

@@ hw/rtl/sppi_checker.sv @@
// Port-level checker for the segment path pose integrator, bound to the top.
// Depends on sppi_pkg.
`timescale 1ns / 1ps

module sppi_checker
  import sppi_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // hold result until transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped before transfer");

  // one segment in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while segment in work");

  // no result right after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result too early");

  // heading stays within one turn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[82:64]) <= 19'sd65536) &&
                      ($signed(m_axis_tdata[82:64]) >= -19'sd65536))
    else $error("heading out of range");

endmodule

bind segment_path_pose_integrator sppi_checker u_sppi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ sim/tb_top.sv @@
// Testbench for segment_path_pose_integrator: drives segments and APB register
// writes, predicts every vertex in a behavioral odometry model and checks it.
// Depends on sppi_pkg and the segment_path_pose_integrator RTL.
`timescale 1ns / 1ps

module tb_top
  import sppi_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int CLIP_RUN_MAX = 400;
  localparam longint unsigned SEG_LEN_K = 64'd9624813;
  localparam longint ROT_GAIN = 64'sd652032874;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;
  localparam int START_HEADING = 16384;
  localparam int TURN_FULL = 65536;
  localparam int TURN_DEFAULT = -26214;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [18:0] heading;
    logic        saturated;
  } vertex_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [MS_W-1:0]        s_axis_tdata;  // [15:0] duration_ms
  logic                   s_axis_tuser;  // [0] start_path
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // [31:0] x_pos, [63:32] y_pos, [82:64] heading, [87:83] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;  // [0] saturated

  // Pose model state and its copy of the registers
  logic [15:0]        speed_cfg;
  logic signed [16:0] turn_cfg;
  int                 pose_x_q;
  int                 pose_y_q;
  int                 heading_q;
  int                 clip_events;

  int atan_units [ATAN_COUNT] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
                                  20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81,
                                  41, 20, 10, 5, 3, 1, 1, 0};

  vertex_t vertex_queue[$];
  int      mismatches;
  int      result_count;
  int      hold_requests;
  bit      quiet_mode;

  segment_path_pose_integrator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [32:0] clamp_pos(input longint v);
    if (v > POS_MAX) begin
      return {1'b1, 32'h7FFF_FFFF};
    end
    if (v < POS_MIN) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[31:0]};
  endfunction

  function automatic vertex_t integrate_segment(input logic [15:0] ms, input logic start);
    longint unsigned prod;
    longint          len;
    longint          cx;
    longint          cy;
    longint          z;
    longint          xs;
    longint          ys;
    longint          c;
    longint          s;
    logic [15:0]     ang;
    bit              clip_x;
    bit              clip_y;
    vertex_t         v;
    prod = 64'(speed_cfg) * 64'(ms);
    len = longint'((prod * SEG_LEN_K + 64'h8000_0000) >> 32);
    if (start) begin
      pose_x_q = 0;
      pose_y_q = 0;
      heading_q = START_HEADING;
    end else begin
      heading_q = heading_q + int'(turn_cfg);
      if (heading_q > TURN_FULL) begin
        heading_q = heading_q - TURN_FULL;
      end else if (heading_q < -TURN_FULL) begin
        heading_q = heading_q + TURN_FULL;
      end
    end
    ang = heading_q[15:0];
    z = longint'({50'd0, ang[13:0]}) * 256;
    cx = ((len * ROT_GAIN + (64'sd1 <<< 29)) >>> 30) * 256;
    cy = 0;
    for (int i = 0; i < CORDIC_ITERATIONS && i < ATAN_COUNT; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (z >= 0) begin
        cx = cx - ys;
        cy = cy + xs;
        z = z - atan_units[i];
      end else begin
        cx = cx + ys;
        cy = cy - xs;
        z = z + atan_units[i];
      end
    end
    case (ang[15:14])
      2'd0: begin
        c = cx;
        s = cy;
      end
      2'd1: begin
        c = -cy;
        s = cx;
      end
      2'd2: begin
        c = -cx;
        s = -cy;
      end
      default: begin
        c = cy;
        s = -cx;
      end
    endcase
    {clip_x, pose_x_q} = clamp_pos(longint'(pose_x_q) + ((c + 128) >>> 8));
    {clip_y, pose_y_q} = clamp_pos(longint'(pose_y_q) + ((s + 128) >>> 8));
    if (clip_x || clip_y) begin
      clip_events++;
    end
    v.x = pose_x_q;
    v.y = pose_y_q;
    v.heading = heading_q[18:0];
    v.saturated = clip_x || clip_y;
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end
    if (r < 94) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(10, 48);
  endfunction

  function automatic logic [15:0] pick_duration();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      return 16'd0;
    end
    if (r == 1) begin
      return 16'hFFFF;
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch in %s at result %0d: got %h, expected %h",
             what, result_count, got, want);
    mismatches++;
  endtask

  task automatic apb_access(input reg_idx_e idx, input logic write,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_register(input reg_idx_e idx, input logic [31:0] want);
    logic [31:0] got;
    logic [31:0] mask;
    mask = (idx == REG_SPEED) ? 32'h0000_FFFF : 32'h0001_FFFF;
    apb_access(idx, 1'b0, 32'd0, got);
    if ((got & mask) !== (want & mask)) begin
      report_mismatch("register readback", 64'(got & mask), 64'(want & mask));
    end
  endtask

  task automatic drain_segments();
    s_axis_tvalid <= 1'b0;
    while (vertex_queue.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_register(input reg_idx_e idx, input logic [31:0] value);
    logic [31:0] unused;
    drain_segments();
    apb_access(idx, 1'b1, value, unused);
    if (idx == REG_SPEED) begin
      speed_cfg = value[15:0];
    end else begin
      turn_cfg = value[16:0];
    end
    check_register(idx, value);
  endtask

  task automatic send_segment(input logic [15:0] ms, input logic start);
    int gap;
    gap = quiet_mode ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ms;
    s_axis_tuser <= start;
    do @(posedge clk_i); while (!s_axis_tready);
    vertex_queue.push_back(integrate_segment(ms, start));
  endtask

  task automatic test_reset_state();
    check_register(REG_SPEED, 32'd0);
    check_register(REG_TURN, 32'(TURN_DEFAULT));
    // turn from the reset pose, zero speed keeps the origin
    send_segment(16'd1234, 1'b0);
    send_segment(16'hFFFF, 1'b1);
  endtask

  task automatic test_turns_and_lengths();
    set_register(REG_SPEED, 32'h0000_FFFF);
    send_segment(16'hFFFF, 1'b1);
    repeat (4) send_segment(16'hFFFF, 1'b0);
    send_segment(16'd0, 1'b0);
    // wrap above a full turn
    set_register(REG_TURN, 32'h0000_FFFF);
    send_segment(16'd1000, 1'b1);
    repeat (3) send_segment(16'd1000, 1'b0);
    // land exactly on a full turn and hold it
    set_register(REG_TURN, 32'd49152);
    send_segment(16'd500, 1'b1);
    send_segment(16'd500, 1'b0);
    set_register(REG_TURN, 32'd0);
    send_segment(16'd500, 1'b0);
    // exactly minus a full turn, then wrap below it
    set_register(REG_TURN, 32'(-16384));
    send_segment(16'd300, 1'b1);
    send_segment(16'd300, 1'b0);
    set_register(REG_TURN, 32'h0001_0000);
    send_segment(16'd300, 1'b0);
    send_segment(16'd300, 1'b0);
    set_register(REG_SPEED, 32'd1);
    send_segment(16'd1, 1'b1);
    send_segment(16'hFFFF, 1'b0);
  endtask

  task automatic test_position_clip();
    int target;
    int legs;
    set_register(REG_SPEED, 32'h0000_FFFF);
    for (int run = 0; run < 2; run++) begin
      set_register(REG_TURN, (run == 0) ? 32'd0 : 32'd16384);
      send_segment(16'hFFFF, 1'b1);
      if (run == 1) begin
        send_segment(16'hFFFF, 1'b0);
        set_register(REG_TURN, 32'd0);
      end
      target = clip_events + 6;
      legs = 0;
      while (clip_events < target && legs < CLIP_RUN_MAX) begin
        send_segment(16'($urandom_range(60000, 65535)), 1'b0);
        legs++;
      end
    end
  endtask

  task automatic test_output_backpressure();
    set_register(REG_TURN, 32'($urandom_range(0, 131071)));
    quiet_mode = 1'b1;
    hold_requests++;
    repeat (24) send_segment(pick_duration(), $urandom_range(0, 3) == 0);
    drain_segments();
    quiet_mode = 1'b0;
  endtask

  task automatic test_random_paths();
    int sent;
    int legs;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin
          set_register(REG_SPEED, 32'h0000_FFFF);
          set_register(REG_TURN, 32'($urandom_range(0, 131071)));
        end
        1: begin
          set_register(REG_SPEED, 32'd0);
        end
        2: begin
          set_register(REG_SPEED, 32'($urandom_range(0, 65535)));
          set_register(REG_TURN, 32'h0001_0000);
        end
        3: begin
          set_register(REG_SPEED, 32'($urandom_range(0, 65535)));
          set_register(REG_TURN, 32'h0000_FFFF);
        end
        default: begin
          set_register(REG_SPEED, 32'($urandom_range(0, 65535)));
          set_register(REG_TURN, 32'($urandom_range(0, 131071)));
        end
      endcase
      quiet_mode = (phase == 4);
      sent = 0;
      while (sent < 160) begin
        if ($urandom_range(0, 9) < 8) begin
          legs = $urandom_range(1, 10);
          send_segment(pick_duration(), 1'b1);
          repeat (legs) send_segment(pick_duration(), 1'b0);
          sent += legs + 1;
        end else begin
          legs = $urandom_range(1, 4);
          repeat (legs) send_segment(pick_duration(), 1'($urandom_range(0, 1)));
          sent += legs;
        end
      end
      quiet_mode = 1'b0;
    end
  endtask

  // Output side: random stalls, plus long hold-offs on request
  initial begin
    int stall_left;
    int holds_served;
    stall_left = 0;
    holds_served = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served++;
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!quiet_mode) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // Compare each output transfer with the oldest predicted vertex
  initial begin
    vertex_t want;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (vertex_queue.size() == 0) begin
          report_mismatch("unexpected result", 64'(m_axis_tdata[63:0]), 64'd0);
        end else begin
          want = vertex_queue.pop_front();
          if (m_axis_tdata[31:0] !== want.x) begin
            report_mismatch("x_pos", 64'(m_axis_tdata[31:0]), 64'(want.x));
          end
          if (m_axis_tdata[63:32] !== want.y) begin
            report_mismatch("y_pos", 64'(m_axis_tdata[63:32]), 64'(want.y));
          end
          if (m_axis_tdata[82:64] !== want.heading) begin
            report_mismatch("heading", 64'(m_axis_tdata[82:64]), 64'(want.heading));
          end
          if (m_axis_tuser !== want.saturated) begin
            report_mismatch("saturated", 64'(m_axis_tuser), 64'(want.saturated));
          end
        end
        result_count++;
      end
    end
  end

  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    speed_cfg = 16'd0;
    turn_cfg = 17'(TURN_DEFAULT);
    pose_x_q = 0;
    pose_y_q = 0;
    heading_q = 0;
    clip_events = 0;
    mismatches = 0;
    result_count = 0;
    hold_requests = 0;
    quiet_mode = 1'b0;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_turns_and_lengths();
    test_position_clip();
    test_output_backpressure();
    test_random_paths();
    drain_segments();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ segment_path_pose_integrator.f @@
hw/rtl/sppi_pkg.sv
hw/rtl/sppi_cfg.sv
hw/rtl/sppi_ctrl.sv
hw/rtl/sppi_datapath.sv
hw/rtl/segment_path_pose_integrator.sv
hw/rtl/sppi_checker.sv
sim/tb_top.sv
